// ----- src/ffra_pkg.sv -----
// Package: constants, types and helpers of the first-fit region allocator.
package ffra_pkg;

	localparam int MAX_REGIONS = 32;
	localparam int NUM_POOLS   = 6;
	localparam int SZ_W        = 31;
	localparam int ALIGN_W     = 9;
	localparam int POOL_W      = 3;
	localparam int IDX_W       = (MAX_REGIONS > 1) ? $clog2(MAX_REGIONS) : 1;
	localparam int CNT_W       = $clog2(MAX_REGIONS + 2);
	localparam int DEPTH       = NUM_POOLS * MAX_REGIONS;
	localparam int ADDR_W      = $clog2(DEPTH);
	localparam int PIDX_W      = (NUM_POOLS > 1) ? $clog2(NUM_POOLS) : 1;
	localparam int CFG_IDX_W   = 3;

	localparam logic [ALIGN_W-1:0] MAPPED_ALIGN = ALIGN_W'(4);
	localparam logic [ALIGN_W-1:0] RST_ALIGN    = ALIGN_W'(256);
	localparam logic [SZ_W-1:0]    RST_BIG_SIZE = SZ_W'(16777216);
	localparam logic [SZ_W-1:0]    RST_UNI_SIZE = SZ_W'(65536);

	localparam logic OP_ALLOC = 1'b0;
	localparam logic OP_FREE  = 1'b1;

	localparam logic [POOL_W-1:0] POOL_SHARED  = 3'd2;
	localparam logic [POOL_W-1:0] POOL_INPUT   = 3'd3;
	localparam logic [POOL_W-1:0] POOL_OUTPUT  = 3'd4;
	localparam logic [POOL_W-1:0] POOL_UNIFORM = 3'd5;

	typedef enum logic [2:0] {
		ST_OK      = 3'd0,
		ST_NOFIT   = 3'd1,
		ST_UNKNOWN = 3'd2,
		ST_DOUBLE  = 3'd3,
		ST_FULL    = 3'd4
	} status_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_STORAGE_ALIGN = 3'd0,
		CFG_UNIFORM_ALIGN = 3'd1,
		CFG_STORAGE_SIZE  = 3'd2,
		CFG_INPUT_SIZE    = 3'd3,
		CFG_OUTPUT_SIZE   = 3'd4,
		CFG_UNIFORM_SIZE  = 3'd5
	} cfg_idx_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_ROUND,
		S_SCAN_RD,
		S_SCAN_CHK,
		S_SHR_RD,
		S_SHR_WR,
		S_SPLIT_A,
		S_SPLIT_B,
		S_NEXT_CHK,
		S_MERGE,
		S_SHL_RD,
		S_SHL_WR,
		S_DONE
	} fsm_state_t;

	typedef struct packed {
		logic            is_free;
		logic [SZ_W-1:0] offset;
		logic [SZ_W-1:0] size;
	} entry_t;

	function automatic logic [ADDR_W-1:0] tbl_addr(input logic [PIDX_W-1:0] p,
			input logic [IDX_W-1:0] idx);
		tbl_addr = ADDR_W'(int'(p) * MAX_REGIONS + int'(idx));
	endfunction

endpackage

// ----- src/ffra_req_if.sv -----
// Request channel interface.
interface ffra_req_if;
	logic                       valid;
	logic                       ready;
	logic                       operation;
	logic [ffra_pkg::POOL_W-1:0] pool;
	logic [ffra_pkg::SZ_W-1:0]   request_size;
	logic [ffra_pkg::SZ_W-1:0]   free_offset;

	modport source (output valid, operation, pool, request_size, free_offset, input ready);
	modport sink (input valid, operation, pool, request_size, free_offset, output ready);
endinterface

// ----- src/ffra_rsp_if.sv -----
// Result channel interface.
interface ffra_rsp_if;
	logic                     valid;
	logic                     ready;
	logic [2:0]               status;
	logic [ffra_pkg::SZ_W-1:0] granted_offset;
	logic [ffra_pkg::SZ_W-1:0] granted_size;

	modport source (output valid, status, granted_offset, granted_size, input ready);
	modport sink (input valid, status, granted_offset, granted_size, output ready);
endinterface

// ----- src/ffra_table_ram.sv -----
// Region table memory: one write port, one registered read port.
module ffra_table_ram (
	input  logic                          clk,
	input  logic                          wr_en,
	input  logic [ffra_pkg::ADDR_W-1:0]   wr_addr,
	input  ffra_pkg::entry_t              wr_data,
	input  logic                          rd_en,
	input  logic [ffra_pkg::ADDR_W-1:0]   rd_addr,
	output ffra_pkg::entry_t              rd_data
);

	ffra_pkg::entry_t mem [ffra_pkg::DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

// ----- src/ffra_round.sv -----
// Bit-serial remainder unit that rounds a size up to an alignment.
module ffra_round (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           start,
	input  logic [ffra_pkg::SZ_W-1:0]      req_size,
	input  logic [ffra_pkg::ALIGN_W-1:0]   align,
	output logic                           done,
	output logic [ffra_pkg::SZ_W:0]        need
);

	localparam int STEP_W = $clog2(ffra_pkg::SZ_W);
	localparam int REM_W  = ffra_pkg::ALIGN_W;

	logic                         busy_q;
	logic                         done_q;
	logic [STEP_W-1:0]            step_q;
	logic [REM_W-1:0]             rem_q;
	logic [ffra_pkg::SZ_W-1:0]    sh_q;
	logic [ffra_pkg::SZ_W-1:0]    req_q;
	logic [ffra_pkg::ALIGN_W-1:0] a_q;
	logic [ffra_pkg::ALIGN_W:0]   trial;
	logic [ffra_pkg::ALIGN_W:0]   rem_next;

	assign trial    = {rem_q, sh_q[ffra_pkg::SZ_W-1]};
	assign rem_next = (trial >= {1'b0, a_q}) ? trial - {1'b0, a_q} : trial;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			step_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				step_q <= '0;
			end else if (busy_q) begin
				step_q <= step_q + STEP_W'(1);
				if (step_q == STEP_W'(ffra_pkg::SZ_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			a_q   <= (align == '0) ? ffra_pkg::ALIGN_W'(1) : align;
			req_q <= req_size;
			sh_q  <= req_size;
			rem_q <= '0;
		end else if (busy_q) begin
			rem_q <= rem_next[REM_W-1:0];
			sh_q  <= {sh_q[ffra_pkg::SZ_W-2:0], 1'b0};
		end
	end

	assign done = done_q;
	assign need = (rem_q != '0)
		? {1'b0, req_q} + (ffra_pkg::SZ_W+1)'(a_q) - (ffra_pkg::SZ_W+1)'(rem_q)
		: {1'b0, req_q};

endmodule

// ----- src/first_fit_region_allocator.sv -----
// Top level: first-fit region allocator over six pools with one region table memory.
// Allocate: rounding, then a scan of the regions, then a shift of the entries on a split.
// Free: a scan of the regions, then a merge and a shift of the entries.
// The region table memory port allows one read and one write per cycle.
// Reset and pool size writes mark a pool fresh: entry 0 reads as one free region, no clear pass.
// One request in work at a time; a finished result waits in the output register.
module first_fit_region_allocator (
	input  logic                              clk,
	input  logic                              arst_n,
	ffra_req_if.sink                          req,
	ffra_rsp_if.source                        rsp,
	input  logic                              cfg_wen,
	input  logic [ffra_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [ffra_pkg::SZ_W-1:0]         cfg_data
);

	localparam int CW = ffra_pkg::CNT_W;

	ffra_pkg::fsm_state_t state_q, state_d;

	logic [ffra_pkg::ALIGN_W-1:0] st_align_q, uni_align_q;
	logic [ffra_pkg::SZ_W-1:0]    st_size_q, in_size_q, out_size_q, uni_size_q;
	logic [CW-1:0]                cnt_q [ffra_pkg::NUM_POOLS];
	logic [ffra_pkg::NUM_POOLS-1:0] fresh_q;

	logic                          op_q;
	logic [ffra_pkg::POOL_W-1:0]   pool_q;
	logic [ffra_pkg::SZ_W-1:0]     at_q;
	logic [ffra_pkg::SZ_W:0]       need_q;
	logic [CW-1:0]                 i_q, j_q, n_q;
	logic [1:0]                    k_q;
	ffra_pkg::entry_t              ent_q, prev_q;
	logic                          nf_q;
	logic [ffra_pkg::SZ_W-1:0]     nsz_q;
	ffra_pkg::status_t             st_q;
	logic [ffra_pkg::SZ_W-1:0]     off_q, gsz_q;
	logic                          rd_virt_q;

	logic                          out_valid_q;
	ffra_pkg::status_t             out_st_q;
	logic [ffra_pkg::SZ_W-1:0]     out_off_q, out_gsz_q;

	logic                          accept, pool_ok, out_load;
	logic [ffra_pkg::PIDX_W-1:0]   pidx, req_pidx;
	logic [ffra_pkg::SZ_W-1:0]     pool_sz;
	logic [ffra_pkg::ALIGN_W-1:0]  req_align;
	logic                          rnd_start, rnd_done;
	logic [ffra_pkg::SZ_W:0]       rnd_need;
	logic                          rd_en, wr_en;
	logic [CW-1:0]                 rd_idx, wr_idx;
	ffra_pkg::entry_t              wr_data, ram_rd, rd_ent;
	logic                          fit, exact, match, pf;

	assign req_pidx = req.pool[ffra_pkg::PIDX_W-1:0];
	assign pidx     = pool_q[ffra_pkg::PIDX_W-1:0];
	assign pool_ok  = int'(req.pool) < ffra_pkg::NUM_POOLS;
	assign accept   = req.valid && req.ready;
	assign req.ready = (state_q == ffra_pkg::S_IDLE);
	assign rnd_start = accept && pool_ok && (req.operation == ffra_pkg::OP_ALLOC)
		&& (req.request_size != '0);
	assign out_load = (state_q == ffra_pkg::S_DONE) && (!out_valid_q || rsp.ready);

	always_comb begin
		if (req.pool <= ffra_pkg::POOL_SHARED) begin
			req_align = st_align_q;
		end else if (req.pool == ffra_pkg::POOL_UNIFORM) begin
			req_align = uni_align_q;
		end else begin
			req_align = ffra_pkg::MAPPED_ALIGN;
		end
	end

	always_comb begin
		if (pool_q <= ffra_pkg::POOL_SHARED) begin
			pool_sz = st_size_q;
		end else if (pool_q == ffra_pkg::POOL_INPUT) begin
			pool_sz = in_size_q;
		end else if (pool_q == ffra_pkg::POOL_OUTPUT) begin
			pool_sz = out_size_q;
		end else begin
			pool_sz = uni_size_q;
		end
	end

	ffra_round u_round (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (rnd_start),
		.req_size (req.request_size),
		.align    (req_align),
		.done     (rnd_done),
		.need     (rnd_need)
	);

	ffra_table_ram u_ram (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (ffra_pkg::tbl_addr(pidx, wr_idx[ffra_pkg::IDX_W-1:0])),
		.wr_data (wr_data),
		.rd_en   (rd_en),
		.rd_addr (ffra_pkg::tbl_addr(pidx, rd_idx[ffra_pkg::IDX_W-1:0])),
		.rd_data (ram_rd)
	);

	always_comb begin
		if (rd_virt_q) begin
			rd_ent.is_free = 1'b1;
			rd_ent.offset  = '0;
			rd_ent.size    = pool_sz;
		end else begin
			rd_ent = ram_rd;
		end
	end

	assign fit   = rd_ent.is_free && ({1'b0, rd_ent.size} >= need_q);
	assign exact = ({1'b0, rd_ent.size} == need_q);
	assign match = (rd_ent.offset == at_q);
	assign pf    = (i_q != '0) && prev_q.is_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ffra_pkg::S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		rd_en   = 1'b0;
		rd_idx  = '0;
		wr_en   = 1'b0;
		wr_idx  = '0;
		wr_data = '0;
		unique case (state_q)
			ffra_pkg::S_IDLE: begin
				if (req.valid) begin
					if (!pool_ok) begin
						state_d = ffra_pkg::S_DONE;
					end else if (req.operation == ffra_pkg::OP_FREE) begin
						state_d = ffra_pkg::S_SCAN_RD;
					end else if (req.request_size == '0) begin
						state_d = ffra_pkg::S_DONE;
					end else begin
						state_d = ffra_pkg::S_ROUND;
					end
				end
			end
			ffra_pkg::S_ROUND: begin
				if (rnd_done) state_d = ffra_pkg::S_SCAN_RD;
			end
			ffra_pkg::S_SCAN_RD: begin
				if (i_q >= n_q) begin
					state_d = ffra_pkg::S_DONE;
				end else begin
					rd_en   = 1'b1;
					rd_idx  = i_q;
					state_d = ffra_pkg::S_SCAN_CHK;
				end
			end
			ffra_pkg::S_SCAN_CHK: begin
				if (op_q == ffra_pkg::OP_ALLOC) begin
					if (fit) begin
						if (exact) begin
							wr_en           = 1'b1;
							wr_idx          = i_q;
							wr_data         = rd_ent;
							wr_data.is_free = 1'b0;
							state_d         = ffra_pkg::S_DONE;
						end else if (n_q >= CW'(ffra_pkg::MAX_REGIONS)) begin
							state_d = ffra_pkg::S_DONE;
						end else begin
							state_d = ffra_pkg::S_SHR_RD;
						end
					end else begin
						state_d = ffra_pkg::S_SCAN_RD;
					end
				end else if (match) begin
					if (rd_ent.is_free) begin
						state_d = ffra_pkg::S_DONE;
					end else if (i_q + CW'(1) < n_q) begin
						rd_en   = 1'b1;
						rd_idx  = i_q + CW'(1);
						state_d = ffra_pkg::S_NEXT_CHK;
					end else begin
						state_d = ffra_pkg::S_MERGE;
					end
				end else begin
					state_d = ffra_pkg::S_SCAN_RD;
				end
			end
			ffra_pkg::S_SHR_RD: begin
				if (j_q == i_q + CW'(1)) begin
					state_d = ffra_pkg::S_SPLIT_A;
				end else begin
					rd_en   = 1'b1;
					rd_idx  = j_q - CW'(1);
					state_d = ffra_pkg::S_SHR_WR;
				end
			end
			ffra_pkg::S_SHR_WR: begin
				wr_en   = 1'b1;
				wr_idx  = j_q;
				wr_data = rd_ent;
				state_d = ffra_pkg::S_SHR_RD;
			end
			ffra_pkg::S_SPLIT_A: begin
				wr_en           = 1'b1;
				wr_idx          = i_q + CW'(1);
				wr_data.is_free = 1'b1;
				wr_data.offset  = ent_q.offset + need_q[ffra_pkg::SZ_W-1:0];
				wr_data.size    = ent_q.size - need_q[ffra_pkg::SZ_W-1:0];
				state_d         = ffra_pkg::S_SPLIT_B;
			end
			ffra_pkg::S_SPLIT_B: begin
				wr_en           = 1'b1;
				wr_idx          = i_q;
				wr_data.is_free = 1'b0;
				wr_data.offset  = ent_q.offset;
				wr_data.size    = need_q[ffra_pkg::SZ_W-1:0];
				state_d         = ffra_pkg::S_DONE;
			end
			ffra_pkg::S_NEXT_CHK: begin
				state_d = ffra_pkg::S_MERGE;
			end
			ffra_pkg::S_MERGE: begin
				wr_en           = 1'b1;
				wr_data.is_free = 1'b1;
				if (pf) begin
					wr_idx         = i_q - CW'(1);
					wr_data.offset = prev_q.offset;
					wr_data.size   = prev_q.size + ent_q.size + (nf_q ? nsz_q : '0);
					state_d        = ffra_pkg::S_SHL_RD;
				end else begin
					wr_idx         = i_q;
					wr_data.offset = ent_q.offset;
					wr_data.size   = ent_q.size + (nf_q ? nsz_q : '0);
					state_d        = nf_q ? ffra_pkg::S_SHL_RD : ffra_pkg::S_DONE;
				end
			end
			ffra_pkg::S_SHL_RD: begin
				if (j_q >= n_q) begin
					state_d = ffra_pkg::S_DONE;
				end else begin
					rd_en   = 1'b1;
					rd_idx  = j_q;
					state_d = ffra_pkg::S_SHL_WR;
				end
			end
			ffra_pkg::S_SHL_WR: begin
				wr_en   = 1'b1;
				wr_idx  = j_q - CW'(k_q);
				wr_data = rd_ent;
				state_d = ffra_pkg::S_SHL_RD;
			end
			ffra_pkg::S_DONE: begin
				if (out_load) state_d = ffra_pkg::S_IDLE;
			end
			default: state_d = ffra_pkg::S_IDLE;
		endcase
	end

	// per-request datapath
	always_ff @(posedge clk) begin
		rd_virt_q <= rd_en && fresh_q[pidx] && (rd_idx == '0);
		unique case (state_q)
			ffra_pkg::S_IDLE: begin
				if (accept) begin
					op_q   <= req.operation;
					pool_q <= req.pool;
					at_q   <= req.free_offset;
					i_q    <= '0;
					n_q    <= pool_ok ? cnt_q[req_pidx] : '0;
					off_q  <= '0;
					gsz_q  <= '0;
					nf_q   <= 1'b0;
					prev_q <= '0;
					if (!pool_ok) begin
						st_q <= (req.operation == ffra_pkg::OP_FREE)
							? ffra_pkg::ST_UNKNOWN : ffra_pkg::ST_NOFIT;
					end else if (req.operation == ffra_pkg::OP_ALLOC
							&& req.request_size == '0) begin
						st_q <= ffra_pkg::ST_NOFIT;
					end else begin
						st_q <= ffra_pkg::ST_OK;
					end
				end
			end
			ffra_pkg::S_ROUND: begin
				if (rnd_done) need_q <= rnd_need;
			end
			ffra_pkg::S_SCAN_RD: begin
				if (i_q >= n_q) begin
					st_q <= (op_q == ffra_pkg::OP_FREE)
						? ffra_pkg::ST_UNKNOWN : ffra_pkg::ST_NOFIT;
				end
			end
			ffra_pkg::S_SCAN_CHK: begin
				if (op_q == ffra_pkg::OP_ALLOC) begin
					if (fit) begin
						ent_q <= rd_ent;
						if (exact) begin
							off_q <= rd_ent.offset;
							gsz_q <= rd_ent.size;
						end else if (n_q >= CW'(ffra_pkg::MAX_REGIONS)) begin
							st_q <= ffra_pkg::ST_FULL;
						end else begin
							j_q <= n_q;
						end
					end else begin
						i_q <= i_q + CW'(1);
					end
				end else if (match) begin
					if (rd_ent.is_free) begin
						st_q <= ffra_pkg::ST_DOUBLE;
					end else begin
						ent_q <= rd_ent;
						gsz_q <= rd_ent.size;
					end
				end else begin
					prev_q <= rd_ent;
					i_q    <= i_q + CW'(1);
				end
			end
			ffra_pkg::S_SHR_WR: j_q <= j_q - CW'(1);
			ffra_pkg::S_SPLIT_B: begin
				off_q <= ent_q.offset;
				gsz_q <= need_q[ffra_pkg::SZ_W-1:0];
			end
			ffra_pkg::S_NEXT_CHK: begin
				nf_q  <= rd_ent.is_free;
				nsz_q <= rd_ent.size;
			end
			ffra_pkg::S_MERGE: begin
				j_q <= (pf && !nf_q) ? i_q + CW'(1) : i_q + CW'(2);
				k_q <= (pf && nf_q) ? 2'd2 : 2'd1;
			end
			ffra_pkg::S_SHL_WR: j_q <= j_q + CW'(1);
			default: ;
		endcase
	end

	// config registers, region counts and fresh flags
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_align_q  <= ffra_pkg::RST_ALIGN;
			uni_align_q <= ffra_pkg::RST_ALIGN;
			st_size_q   <= ffra_pkg::RST_BIG_SIZE;
			in_size_q   <= ffra_pkg::RST_BIG_SIZE;
			out_size_q  <= ffra_pkg::RST_BIG_SIZE;
			uni_size_q  <= ffra_pkg::RST_UNI_SIZE;
			fresh_q     <= '1;
			for (int p = 0; p < ffra_pkg::NUM_POOLS; p++) begin
				cnt_q[p] <= CW'(1);
			end
		end else begin
			if (wr_en) fresh_q[pidx] <= 1'b0;
			if (state_q == ffra_pkg::S_SPLIT_B) begin
				cnt_q[pidx] <= n_q + CW'(1);
			end
			if (state_q == ffra_pkg::S_SHL_RD && j_q >= n_q) begin
				cnt_q[pidx] <= n_q - CW'(k_q);
			end
			if (cfg_wen) begin
				unique case (cfg_index)
					ffra_pkg::CFG_STORAGE_ALIGN:
						st_align_q <= cfg_data[ffra_pkg::ALIGN_W-1:0];
					ffra_pkg::CFG_UNIFORM_ALIGN:
						uni_align_q <= cfg_data[ffra_pkg::ALIGN_W-1:0];
					ffra_pkg::CFG_STORAGE_SIZE: st_size_q  <= cfg_data;
					ffra_pkg::CFG_INPUT_SIZE:   in_size_q  <= cfg_data;
					ffra_pkg::CFG_OUTPUT_SIZE:  out_size_q <= cfg_data;
					ffra_pkg::CFG_UNIFORM_SIZE: uni_size_q <= cfg_data;
					default: ;
				endcase
				for (int p = 0; p < ffra_pkg::NUM_POOLS; p++) begin
					if ((cfg_index == ffra_pkg::CFG_STORAGE_SIZE
							&& p <= int'(ffra_pkg::POOL_SHARED))
						|| (cfg_index == ffra_pkg::CFG_INPUT_SIZE
							&& p == int'(ffra_pkg::POOL_INPUT))
						|| (cfg_index == ffra_pkg::CFG_OUTPUT_SIZE
							&& p == int'(ffra_pkg::POOL_OUTPUT))
						|| (cfg_index == ffra_pkg::CFG_UNIFORM_SIZE
							&& p == int'(ffra_pkg::POOL_UNIFORM))) begin
						cnt_q[p]   <= (cfg_data != '0) ? CW'(1) : '0;
						fresh_q[p] <= 1'b1;
					end
				end
			end
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			out_st_q  <= st_q;
			out_off_q <= (st_q == ffra_pkg::ST_OK) ? off_q : '0;
			out_gsz_q <= (st_q == ffra_pkg::ST_OK) ? gsz_q : '0;
		end
	end

	assign rsp.valid          = out_valid_q;
	assign rsp.status         = out_st_q;
	assign rsp.granted_offset = out_off_q;
	assign rsp.granted_size   = out_gsz_q;

`ifndef NO_ASSERTIONS
	a_no_write_idle: assert property (@(posedge clk) disable iff (!arst_n)
		wr_en |-> state_q != ffra_pkg::S_IDLE)
		else $error("table write while idle");

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		state_q != ffra_pkg::S_IDLE |-> n_q <= CW'(ffra_pkg::MAX_REGIONS))
		else $error("region count above table depth");

	a_fail_zero: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid && rsp.status != ffra_pkg::ST_OK |->
			rsp.granted_offset == '0 && rsp.granted_size == '0)
		else $error("failed request returned nonzero grant");

	a_done_loads: assert property (@(posedge clk) disable iff (!arst_n)
		out_load |=> out_valid_q && state_q == ffra_pkg::S_IDLE)
		else $error("result not presented after completion");
`endif

endmodule
